@@ design/sbot_pkg.sv @@
// Shared types and constants for the segment versus box overlap test.
package sbot_pkg;

   localparam int TAG_W     = 16;
   localparam int CSR_IDX_W = 3;

   // Pipeline stage numbers; the last stage is the output register.
   localparam int ST_IN    = 0;
   localparam int ST_EXT   = 1;
   localparam int ST_FACE  = 2;
   localparam int ST_PART  = 3;
   localparam int ST_PROD  = 4;
   localparam int ST_CROSS = 5;
   localparam int ST_OUT   = 6;
   localparam int NSTAGE   = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X  = 3'd0,
      CSR_START_Y  = 3'd1,
      CSR_START_Z  = 3'd2,
      CSR_END_X    = 3'd3,
      CSR_END_Y    = 3'd4,
      CSR_END_Z    = 3'd5,
      CSR_FRACTION = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [NSTAGE-1:0] vld;
      logic [NSTAGE-1:0] adv;
   } pipe_ctl_type;

endpackage

@@ design/sbot_req_if.sv @@
// Request channel: one box and its tag.
interface sbot_req_if import sbot_pkg::*; #(
   parameter int COORD_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] box_min_x;
   logic signed [COORD_WIDTH-1:0] box_min_y;
   logic signed [COORD_WIDTH-1:0] box_min_z;
   logic signed [COORD_WIDTH-1:0] box_max_x;
   logic signed [COORD_WIDTH-1:0] box_max_y;
   logic signed [COORD_WIDTH-1:0] box_max_z;
   logic [TAG_W-1:0]              box_tag;

   modport source (
      output valid, box_min_x, box_min_y, box_min_z,
             box_max_x, box_max_y, box_max_z, box_tag,
      input  ready
   );
   modport sink (
      input  valid, box_min_x, box_min_y, box_min_z,
             box_max_x, box_max_y, box_max_z, box_tag,
      output ready
   );
endinterface

@@ design/sbot_rsp_if.sv @@
// Response channel: overlap flag and the returned tag.
interface sbot_rsp_if import sbot_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             hit;
   logic [TAG_W-1:0] result_tag;

   modport source (output valid, hit, result_tag, input ready);
   modport sink   (input valid, hit, result_tag, output ready);
endinterface

@@ design/sbot_pipe_ctrl.sv @@
// Valid bits and per-stage advance enables of the test pipeline.
module sbot_pipe_ctrl import sbot_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         rsp_ready,
   output pipe_ctl_type ctl
);
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] adv;

   // A stage may load when it is empty or its content moves on, so bubbles collapse.
   always_comb begin
      adv[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_ready;
      for (int k = NSTAGE-2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctl.vld = vld_ff;
   assign ctl.adv = adv;
endmodule

@@ design/sbot_prep.sv @@
// Front stages: box capture, extents and offsets, face-axis tests.
module sbot_prep import sbot_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  pipe_ctl_type                  ctl,
   input  logic signed [COORD_WIDTH-1:0] box_lo [3],
   input  logic signed [COORD_WIDTH-1:0] box_hi [3],
   input  logic signed [COORD_WIDTH+3:0] base [3],
   input  logic signed [COORD_WIDTH+2:0] dir [3],
   output logic signed [COORD_WIDTH:0]   ext_out [3],
   output logic signed [COORD_WIDTH+2:0] dir_out [3],
   output logic signed [COORD_WIDTH+3:0] mid_out [3],
   output logic signed [COORD_WIDTH+2:0] adir_out [3],
   output logic                          face_sep_out
);
   localparam int E_W = COORD_WIDTH + 1;
   localparam int D_W = COORD_WIDTH + 3;
   localparam int M_W = COORD_WIDTH + 4;

   logic signed [COORD_WIDTH-1:0] lo_ff [3];
   logic signed [COORD_WIDTH-1:0] hi_ff [3];
   logic signed [E_W-1:0]         ext_in [3];
   logic signed [M_W-1:0]         mid_in [3];
   logic signed [E_W-1:0]         ext1_ff [3];
   logic signed [D_W-1:0]         dir1_ff [3];
   logic signed [M_W-1:0]         mid1_ff [3];
   logic signed [M_W:0]           amid [3];
   logic signed [D_W:0]           adir [3];
   logic signed [M_W:0]           reach [3];
   logic [2:0]                    sep_axis;
   logic signed [D_W-1:0]         adir_in [3];
   logic signed [E_W-1:0]         ext2_ff [3];
   logic signed [D_W-1:0]         dir2_ff [3];
   logic signed [M_W-1:0]         mid2_ff [3];
   logic signed [D_W-1:0]         adir2_ff [3];
   logic                          face_sep_ff;

   always_ff @(posedge clock) begin
      if (ctl.adv[ST_IN]) begin
         lo_ff <= box_lo;
         hi_ff <= box_hi;
      end
   end

   // Doubled extent and doubled midpoint offset.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ext_in[i] = E_W'(hi_ff[i]) - E_W'(lo_ff[i]);
         mid_in[i] = base[i] - M_W'(lo_ff[i]) - M_W'(hi_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[ST_EXT]) begin
         ext1_ff <= ext_in;
         dir1_ff <= dir;
         mid1_ff <= mid_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         amid[i]     = mid1_ff[i][M_W-1] ? -(M_W+1)'(mid1_ff[i]) : (M_W+1)'(mid1_ff[i]);
         adir[i]     = dir1_ff[i][D_W-1] ? -(D_W+1)'(dir1_ff[i]) : (D_W+1)'(dir1_ff[i]);
         reach[i]    = (M_W+1)'(ext1_ff[i]) + (M_W+1)'(adir[i]);
         sep_axis[i] = amid[i] > reach[i];
         // The cross axes see the absolute direction widened by one LSB.
         adir_in[i]  = D_W'(adir[i] + (D_W+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[ST_FACE]) begin
         ext2_ff     <= ext1_ff;
         dir2_ff     <= dir1_ff;
         mid2_ff     <= mid1_ff;
         adir2_ff    <= adir_in;
         face_sep_ff <= |sep_axis;
      end
   end

   assign ext_out      = ext2_ff;
   assign dir_out      = dir2_ff;
   assign mid_out      = mid2_ff;
   assign adir_out     = adir2_ff;
   assign face_sep_out = face_sep_ff;
endmodule

@@ design/sbot_cross.sv @@
// Back stages: split products, cross-axis sums and the final overlap flag.
module sbot_cross import sbot_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  pipe_ctl_type                  ctl,
   input  logic signed [COORD_WIDTH:0]   ext [3],
   input  logic signed [COORD_WIDTH+2:0] dir [3],
   input  logic signed [COORD_WIDTH+3:0] mid [3],
   input  logic signed [COORD_WIDTH+2:0] adir [3],
   input  logic                          face_sep,
   output logic                          hit
);
   localparam int D_W  = COORD_WIDTH + 3;
   localparam int M_W  = COORD_WIDTH + 4;
   localparam int L_W  = (D_W + 1) / 2;
   localparam int H_W  = D_W - L_W;
   localparam int PL_W = M_W + L_W + 1;
   localparam int PH_W = M_W + H_W;
   localparam int P_W  = M_W + D_W;
   localparam int NPRD = 12;

   logic signed [M_W-1:0]  opa [NPRD];
   logic signed [D_W-1:0]  opb [NPRD];
   logic signed [PL_W-1:0] plo_ff [NPRD];
   logic signed [PH_W-1:0] phi_ff [NPRD];
   logic signed [P_W-1:0]  prod_ff [NPRD];
   logic signed [P_W:0]    lhs_ff [3];
   logic signed [P_W:0]    rhs_ff [3];
   logic signed [P_W+1:0]  alhs [3];
   logic [2:0]             sep_axis;
   logic                   face3_ff;
   logic                   face4_ff;
   logic                   face5_ff;
   logic                   hit_ff;

   // Axis pair j uses components (j+1)%3 and (j+2)%3; four products per pair.
   for (genvar j = 0; j < 3; j++) begin : g_pair
      localparam int A = (j + 1) % 3;
      localparam int B = (j + 2) % 3;
      assign opa[4*j]   = mid[A];
      assign opb[4*j]   = dir[B];
      assign opa[4*j+1] = mid[B];
      assign opb[4*j+1] = dir[A];
      assign opa[4*j+2] = M_W'(ext[A]);
      assign opb[4*j+2] = adir[B];
      assign opa[4*j+3] = M_W'(ext[B]);
      assign opb[4*j+3] = adir[A];
   end

   // Each product is cut into a low half (unsigned digit) and a high half (signed digit).
   always_ff @(posedge clock) begin
      if (ctl.adv[ST_PART]) begin
         for (int n = 0; n < NPRD; n++) begin
            plo_ff[n] <= PL_W'(opa[n]) * PL_W'($signed({1'b0, opb[n][L_W-1:0]}));
            phi_ff[n] <= PH_W'(opa[n]) * PH_W'($signed(opb[n][D_W-1:L_W]));
         end
         face3_ff <= face_sep;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[ST_PROD]) begin
         for (int n = 0; n < NPRD; n++) begin
            prod_ff[n] <= (P_W'(phi_ff[n]) <<< L_W) + P_W'(plo_ff[n]);
         end
         face4_ff <= face3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[ST_CROSS]) begin
         for (int j = 0; j < 3; j++) begin
            lhs_ff[j] <= (P_W+1)'(prod_ff[4*j]) - (P_W+1)'(prod_ff[4*j+1]);
            rhs_ff[j] <= (P_W+1)'(prod_ff[4*j+2]) + (P_W+1)'(prod_ff[4*j+3]);
         end
         face5_ff <= face4_ff;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         alhs[j]     = lhs_ff[j][P_W] ? -(P_W+2)'(lhs_ff[j]) : (P_W+2)'(lhs_ff[j]);
         sep_axis[j] = alhs[j] > (P_W+2)'(rhs_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[ST_OUT]) begin
         hit_ff <= !face5_ff && !(|sep_axis);
      end
   end

   assign hit = hit_ff;
endmodule

@@ design/segment_box_overlap_test_top.sv @@
// Segment versus axis-aligned box overlap test, top level.
//
// The segment (start, end and length fraction) is loaded through the csr_
// write port while the block is idle, a rule for the user that the block
// itself does not enforce; it then stays fixed for the boxes that follow.
// Each request on req_bus carries one box (lower and upper corner, signed
// fixed point) and a tag. Each request yields exactly one response on
// rsp_bus with hit set when no separating axis exists, and the request's tag.
// The test runs in a seven-stage pipeline: box capture, extents and offsets,
// face-axis tests, split partial products, product assembly, cross-axis sums,
// and the output register. One request is accepted every cycle unless a
// stalled receiver has filled the pipeline. The segment direction and the
// doubled start point plus direction are recomputed from the configuration
// into registers every cycle, so a request may follow a write from the next
// cycle on. When the receiver stalls, stages behind the output register keep
// filling until the pipeline is full; only then is req_bus.ready lowered.
// Reset clears all valid bits and returns the segment to the origin with a
// length fraction of one; requests are refused while reset is high.
module segment_box_overlap_test_top import sbot_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [((COORD_WIDTH > FRAC_BITS) ? COORD_WIDTH : FRAC_BITS+1)-1:0] csr_wdata,
   sbot_req_if.sink               req_bus,
   sbot_rsp_if.source             rsp_bus
);
   localparam int D_W  = COORD_WIDTH + 3;
   localparam int M_W  = COORD_WIDTH + 4;
   localparam int PR_W = COORD_WIDTH + FRAC_BITS + 3;

   pipe_ctl_type                  ctl;
   logic signed [COORD_WIDTH-1:0] start_ff [3];
   logic signed [COORD_WIDTH-1:0] end_ff [3];
   logic [FRAC_BITS:0]            frac_ff;
   logic signed [COORD_WIDTH:0]   span [3];
   logic signed [PR_W-1:0]        scaled [3];
   logic signed [D_W-1:0]         dir_in [3];
   logic signed [M_W-1:0]         base_in [3];
   logic signed [D_W-1:0]         dir_ff [3];
   logic signed [M_W-1:0]         base_ff [3];
   logic signed [COORD_WIDTH-1:0] box_lo [3];
   logic signed [COORD_WIDTH-1:0] box_hi [3];
   logic signed [COORD_WIDTH:0]   ext [3];
   logic signed [D_W-1:0]         dir_p [3];
   logic signed [M_W-1:0]         mid [3];
   logic signed [D_W-1:0]         adir [3];
   logic                          face_sep;
   logic                          hit;
   logic [TAG_W-1:0]              tag_ff [NSTAGE];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= '0;
            end_ff[i]   <= '0;
         end
         frac_ff <= {1'b1, {FRAC_BITS{1'b0}}};
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_START_X:  start_ff[0] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_START_Y:  start_ff[1] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_START_Z:  start_ff[2] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_END_X:    end_ff[0]   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_END_Y:    end_ff[1]   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_END_Z:    end_ff[2]   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_FRACTION: frac_ff     <= csr_wdata[FRAC_BITS:0];
            default: begin
            end
         endcase
      end
   end

   // Shortened direction and doubled start point plus direction, per axis.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         span[i]    = (COORD_WIDTH+1)'(end_ff[i]) - (COORD_WIDTH+1)'(start_ff[i]);
         scaled[i]  = PR_W'($signed({1'b0, frac_ff})) * PR_W'(span[i]);
         dir_in[i]  = D_W'(scaled[i] >>> FRAC_BITS);
         base_in[i] = (M_W'(start_ff[i]) <<< 1) + M_W'(dir_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      dir_ff  <= dir_in;
      base_ff <= base_in;
   end

   sbot_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl)
   );

   assign box_lo[0] = req_bus.box_min_x;
   assign box_lo[1] = req_bus.box_min_y;
   assign box_lo[2] = req_bus.box_min_z;
   assign box_hi[0] = req_bus.box_max_x;
   assign box_hi[1] = req_bus.box_max_y;
   assign box_hi[2] = req_bus.box_max_z;

   sbot_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
      .clock        (clock),
      .ctl          (ctl),
      .box_lo       (box_lo),
      .box_hi       (box_hi),
      .base         (base_ff),
      .dir          (dir_ff),
      .ext_out      (ext),
      .dir_out      (dir_p),
      .mid_out      (mid),
      .adir_out     (adir),
      .face_sep_out (face_sep)
   );

   sbot_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clock    (clock),
      .ctl      (ctl),
      .ext      (ext),
      .dir      (dir_p),
      .mid      (mid),
      .adir     (adir),
      .face_sep (face_sep),
      .hit      (hit)
   );

   always_ff @(posedge clock) begin
      if (ctl.adv[ST_IN]) begin
         tag_ff[0] <= req_bus.box_tag;
      end
      for (int k = 1; k < NSTAGE; k++) begin
         if (ctl.adv[k]) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign req_bus.ready      = ctl.adv[ST_IN] && !reset;
   assign rsp_bus.valid      = ctl.vld[ST_OUT];
   assign rsp_bus.hit        = hit;
   assign rsp_bus.result_tag = tag_ff[ST_OUT];

`ifndef SYNTH
   // Requests are only refused when every stage holds an item.
   a_ready_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (&ctl.vld))
      else $error("request refused while the pipeline has a free stage");

   // Reset empties the whole pipeline.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (ctl.vld == '0))
      else $error("pipeline holds items after reset");

   // A waiting response keeps its tag until it is taken.
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      ctl.vld[ST_OUT] && !rsp_bus.ready |=> ctl.vld[ST_OUT] && $stable(tag_ff[ST_OUT]))
      else $error("stalled response lost or changed");
`endif
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the segment versus axis-aligned box overlap block.
module tb_top;
   import sbot_pkg::*;

   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int UNIT    = 1 << FRAC_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [COORD_W-1:0]   C_MIN     = 32'h8000_0000;
   localparam logic [COORD_W-1:0]   C_MAX     = 32'h7FFF_FFFF;

   typedef logic signed [127:0] wide_type;
   typedef logic [2:0][COORD_W-1:0] coord3_type;
   typedef struct packed {
      coord3_type       lo;
      coord3_type       hi;
      logic [TAG_W-1:0] tag;
   } box_type;
   typedef struct packed {
      logic             hit;
      logic [TAG_W-1:0] tag;
   } verdict_type;

   typedef enum int {
      SET_MODERATE, SET_FULL_RANGE, SET_NO_LENGTH, SET_OVERLONG,
      SET_POINT, SET_ONE_AXIS, SET_WILD, SET_TINY, SET_COUNT
   } setting_type;

   // Holds the segment registers and the verdicts still owed by the block.
   class overlap_book;
      coord3_type      seg_from;
      coord3_type      seg_to;
      logic [FRAC_W:0] frac;
      verdict_type     awaited[$];
      int              mismatches;
      int              hits;
      int              misses;
      int              boxes;

      function new();
         seg_from   = '0;
         seg_to     = '0;
         frac       = {1'b1, {FRAC_W{1'b0}}};
         mismatches = 0;
         hits       = 0;
         misses     = 0;
         boxes      = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
         case (idx)
            CSR_START_X:  seg_from[0] = data;
            CSR_START_Y:  seg_from[1] = data;
            CSR_START_Z:  seg_from[2] = data;
            CSR_END_X:    seg_to[0]   = data;
            CSR_END_Y:    seg_to[1]   = data;
            CSR_END_Z:    seg_to[2]   = data;
            CSR_FRACTION: frac        = data[FRAC_W:0];
            default: ;
         endcase
      endfunction

      function wide_type magnitude(input wide_type v);
         return (v < 0) ? -v : v;
      endfunction

      // All quantities are doubled so that the midpoint stays an integer.
      function bit segment_meets_box(input box_type b);
         wide_type s, t, p2, fr, lo_w, hi_w;
         wide_type e[3], d[3], m[3], ad[3];
         fr = {111'd0, frac};
         for (int i = 0; i < 3; i++) begin
            s     = signed'(seg_from[i]);
            t     = signed'(seg_to[i]);
            lo_w  = signed'(b.lo[i]);
            hi_w  = signed'(b.hi[i]);
            p2    = s + ((fr * (t - s)) >>> FRAC_W);
            e[i]  = hi_w - lo_w;
            d[i]  = p2 - s;
            m[i]  = s + p2 - lo_w - hi_w;
            ad[i] = magnitude(d[i]);
            if (magnitude(m[i]) > e[i] + ad[i]) return 1'b0;
         end
         // The cross axes use the absolute direction padded by one LSB.
         for (int i = 0; i < 3; i++) ad[i] = ad[i] + 1;
         if (magnitude(m[1] * d[2] - m[2] * d[1]) > e[1] * ad[2] + e[2] * ad[1]) return 1'b0;
         if (magnitude(m[2] * d[0] - m[0] * d[2]) > e[0] * ad[2] + e[2] * ad[0]) return 1'b0;
         if (magnitude(m[0] * d[1] - m[1] * d[0]) > e[0] * ad[1] + e[1] * ad[0]) return 1'b0;
         return 1'b1;
      endfunction

      task report(input string msg);
         mismatches++;
         if (mismatches <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      task note_request(input box_type b);
         verdict_type v;
         v.hit = segment_meets_box(b);
         v.tag = b.tag;
         awaited.push_back(v);
         boxes++;
      endtask

      task check_response(input logic hit, input logic [TAG_W-1:0] tag);
         verdict_type v;
         if (awaited.size() == 0) begin
            report($sformatf("response hit=%b tag=%h with no request outstanding", hit, tag));
            return;
         end
         v = awaited.pop_front();
         if (hit !== v.hit)
            report($sformatf("tag %h: hit=%b, predicted %b", v.tag, hit, v.hit));
         if (tag !== v.tag)
            report($sformatf("result_tag=%h, predicted %h", tag, v.tag));
         if (v.hit) hits++;
         else misses++;
      endtask

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;

   sbot_req_if #(.COORD_WIDTH(COORD_W)) req_bus ();
   sbot_rsp_if rsp_bus ();

   segment_box_overlap_test_top #(
      .COORD_WIDTH(COORD_W),
      .FRAC_BITS  (FRAC_W)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus)
   );

   overlap_book book;
   int rx_hold   = 0;
   int settings  = 0;
   int in_stalls = 0;
   bit rx_calm   = 1'b0;
   bit tx_calm   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d responses outstanding.", book.pending());
      $display("*** FAILED ***");
      $finish;
   end

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      if (r < 99) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
      if (v > 64'sd2147483647) return C_MAX;
      if (v < -64'sd2147483648) return C_MIN;
      return v[COORD_W-1:0];
   endfunction

   function automatic coord3_type xyz(input int x, input int y, input int z);
      coord3_type c;
      c[0] = x;
      c[1] = y;
      c[2] = z;
      return c;
   endfunction

   function automatic coord3_type span3(input int bits);
      coord3_type c;
      for (int i = 0; i < 3; i++)
         c[i] = int'($urandom_range(0, 2 << bits)) - (1 << bits);
      return c;
   endfunction

   function automatic box_type mk(input coord3_type lo, input coord3_type hi,
                                  input logic [TAG_W-1:0] tag);
      box_type b;
      b.lo  = lo;
      b.hi  = hi;
      b.tag = tag;
      return b;
   endfunction

   function automatic logic [COORD_W-1:0] extreme();
      case ($urandom_range(0, 6))
         0: return C_MIN;
         1: return C_MAX;
         2: return '0;
         3: return 32'd1;
         4: return '1;
         5: return C_MIN + 1;
         default: return C_MAX - 1;
      endcase
   endfunction

   // Most boxes sit around a point of the segment so that hits and misses both occur.
   function automatic box_type random_box();
      box_type    b;
      int         style, k, j;
      longint     a, z, base, lim, off;
      logic [COORD_W-1:0] tmp;
      style = $urandom_range(0, 99);
      b.tag = TAG_W'($urandom());
      for (int i = 0; i < 3; i++) begin
         if (style < 20) begin
            b.lo[i] = $urandom();
            b.hi[i] = $urandom();
         end else if (style < 30) begin
            b.lo[i] = extreme();
            b.hi[i] = extreme();
         end else begin
            a    = longint'(signed'(book.seg_from[i]));
            z    = longint'(signed'(book.seg_to[i]));
            base = a + ((z - a) * longint'($urandom_range(0, 256))) / 256;
            k    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 16);
            lim  = longint'(1) << k;
            off  = longint'($urandom_range(0, 32'(2 * lim))) - lim;
            b.lo[i] = clamp_coord(base + off - longint'($urandom_range(0, 32'(lim))));
            b.hi[i] = clamp_coord(base + off + longint'($urandom_range(0, 32'(lim))));
         end
      end
      // Some near boxes are turned inside out on one axis.
      if (style >= 30 && style < 40) begin
         j       = $urandom_range(0, 2);
         tmp     = b.lo[j];
         b.lo[j] = b.hi[j];
         b.hi[j] = tmp;
      end
      return b;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with valid still high.
   task automatic offer(input box_type b);
      req_bus.valid     <= 1'b1;
      req_bus.box_min_x <= b.lo[0];
      req_bus.box_min_y <= b.lo[1];
      req_bus.box_min_z <= b.lo[2];
      req_bus.box_max_x <= b.hi[0];
      req_bus.box_max_y <= b.hi[1];
      req_bus.box_max_z <= b.hi[2];
      req_bus.box_tag   <= b.tag;
      @(posedge clock);
      while (!req_bus.ready) begin
         in_stalls++;
         @(posedge clock);
      end
      book.note_request(b);
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (book.pending() != 0);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      book.set_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic load_segment(input coord3_type from, input coord3_type to,
                               input logic [COORD_W-1:0] frac_word, input bit spare);
      settle();
      put_reg(CSR_START_X, from[0]);
      put_reg(CSR_START_Y, from[1]);
      put_reg(CSR_START_Z, from[2]);
      put_reg(CSR_END_X, to[0]);
      put_reg(CSR_END_Y, to[1]);
      put_reg(CSR_END_Z, to[2]);
      put_reg(CSR_FRACTION, frac_word);
      if (spare) put_reg(CSR_SPARE, $urandom());
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   initial begin : receiver
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rx_hold--;
         end else begin
            if (stall_left == 0 && !rx_calm) stall_left = idle_len();
            if (stall_left > 0) begin
               rsp_bus.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         book.check_response(rsp_bus.hit, rsp_bus.result_tag);
   end

   initial begin : stimulus
      coord3_type  p, q;
      int          gap;
      setting_type kind;
      book              = new();
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.box_min_x = '0;
      req_bus.box_min_y = '0;
      req_bus.box_min_z = '0;
      req_bus.box_max_x = '0;
      req_bus.box_max_y = '0;
      req_bus.box_max_z = '0;
      req_bus.box_tag   = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // After reset the segment is a single point at the origin.
      offer(mk(xyz(-1, -1, -1), xyz(1, 1, 1), 16'h0000));
      offer(mk(xyz(1, 1, 1), xyz(2, 2, 2), 16'hFFFF));
      offer(mk(xyz(0, 0, 0), xyz(0, 0, 0), 16'h0001));
      offer(mk(xyz(1, 1, 1), xyz(-1, -1, -1), 16'h0002));
      offer(mk(xyz(C_MIN, C_MIN, C_MIN), xyz(C_MAX, C_MAX, C_MAX), 16'h8000));
      offer(mk(xyz(C_MAX, C_MAX, C_MAX), xyz(C_MAX, C_MAX, C_MAX), 16'h7FFF));
      offer(mk(xyz(C_MIN, C_MIN, C_MIN), xyz(C_MIN, C_MIN, C_MIN), 16'h5555));

      // Diagonal across the whole coordinate range.
      load_segment(xyz(C_MIN, C_MIN, C_MIN), xyz(C_MAX, C_MAX, C_MAX), UNIT, 1'b0);
      offer(mk(xyz(C_MIN, C_MIN, C_MIN), xyz(C_MAX, C_MAX, C_MAX), 16'hAAAA));
      offer(mk(xyz(0, 0, 0), xyz(0, 0, 0), 16'h0003));
      offer(mk(xyz(C_MAX, C_MAX, C_MAX), xyz(C_MAX, C_MAX, C_MAX), 16'h0004));
      offer(mk(xyz(C_MIN, C_MIN, C_MIN), xyz(C_MIN, C_MIN, C_MIN), 16'h0005));
      offer(mk(xyz(C_MIN, C_MAX - 1, 0), xyz(C_MIN + 1, C_MAX, 0), 16'h0006));
      offer(mk(xyz(-UNIT, UNIT, -UNIT), xyz(UNIT, -UNIT, UNIT), 16'h0007));

      // A zero fraction collapses the segment onto its start; the spare index is written too.
      load_segment(xyz(UNIT, 2 * UNIT, 3 * UNIT), xyz(-5 * UNIT, 7 * UNIT, 100 * UNIT),
                   '0, 1'b1);
      offer(mk(xyz(UNIT - 4, 2 * UNIT - 4, 3 * UNIT - 4),
               xyz(UNIT + 4, 2 * UNIT + 4, 3 * UNIT + 4), 16'h0008));
      offer(mk(xyz(-6 * UNIT, 6 * UNIT, 99 * UNIT), xyz(-4 * UNIT, 8 * UNIT, 101 * UNIT),
               16'h0009));

      // All bits set: the fraction keeps its low bits and reaches nearly twice the length.
      load_segment(xyz(0, 0, 0), xyz(10 * UNIT, 10 * UNIT, 10 * UNIT), 32'hFFFF_FFFF, 1'b0);
      offer(mk(xyz(14 * UNIT, 14 * UNIT, 14 * UNIT), xyz(16 * UNIT, 16 * UNIT, 16 * UNIT),
               16'h000A));
      offer(mk(xyz(24 * UNIT, 24 * UNIT, 24 * UNIT), xyz(26 * UNIT, 26 * UNIT, 26 * UNIT),
               16'h000B));
      offer(mk(xyz(9 * UNIT, 9 * UNIT, 9 * UNIT), xyz(11 * UNIT, 11 * UNIT, 11 * UNIT),
               16'h000C));

      // Start and end coincide, so the segment is tested as a point.
      p = xyz(3 * UNIT, -4 * UNIT, 5 * UNIT);
      load_segment(p, p, UNIT, 1'b0);
      offer(mk(p, p, 16'h000D));
      offer(mk(xyz(3 * UNIT + 1, -4 * UNIT, 5 * UNIT), xyz(4 * UNIT, -3 * UNIT, 6 * UNIT),
               16'h000E));
      offer(mk(xyz(2 * UNIT, -5 * UNIT, 4 * UNIT), xyz(4 * UNIT, -3 * UNIT, 6 * UNIT),
               16'h000F));

      for (int ph = 0; ph < SET_COUNT; ph++) begin
         kind = setting_type'(ph);
         case (kind)
            SET_MODERATE: begin
               p = span3(20);
               q = span3(20);
               load_segment(p, q, $urandom_range(0, UNIT), 1'b0);
            end
            SET_FULL_RANGE:
               load_segment(xyz(C_MIN, C_MAX, C_MIN), xyz(C_MAX, C_MIN, C_MAX), UNIT, 1'b0);
            SET_NO_LENGTH: begin
               p = span3(18);
               q = span3(18);
               load_segment(p, q, '0, 1'b1);
            end
            SET_OVERLONG: begin
               p = span3(18);
               q = span3(18);
               load_segment(p, q, 32'hFFFF_FFFF, 1'b0);
            end
            SET_POINT: begin
               p = span3(16);
               load_segment(p, p, $urandom_range(0, UNIT), 1'b0);
            end
            SET_ONE_AXIS: begin
               p    = span3(20);
               q    = p;
               q[0] = p[0] + $urandom_range(1, 1 << 22);
               load_segment(p, q, UNIT, 1'b0);
            end
            SET_WILD: begin
               p = {$urandom(), $urandom(), $urandom()};
               q = {$urandom(), $urandom(), $urandom()};
               load_segment(p, q, $urandom(), 1'b1);
            end
            default: begin
               p = span3(10);
               q = span3(10);
               load_segment(p, q, $urandom_range(0, 2 * UNIT - 1), 1'b0);
            end
         endcase
         tx_calm = (kind == SET_OVERLONG);
         rx_calm = (kind == SET_OVERLONG);
         for (int n = 0; n < 180; n++) begin
            // Hold the response side off while requests keep coming, so the pipeline fills.
            if (kind == SET_POINT && n == 40) rx_hold = 80;
            if (kind == SET_ONE_AXIS && n == 90) settle();
            offer(random_box());
            if (kind == SET_POINT && n >= 40 && n < 100) gap = 0;
            else gap = tx_calm ? 0 : idle_len();
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end

      settle();
      repeat (20) @(negedge clock);
      $display("Checked %0d boxes (%0d hits, %0d misses) over %0d segment settings.",
               book.boxes, book.hits, book.misses, settings);
      $display("Requests were held back on %0d cycles by a full pipeline or stalled output.",
               in_stalls);
      if (book.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches found.", book.mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/sbot_pkg.sv
design/sbot_req_if.sv
design/sbot_rsp_if.sv
design/sbot_pipe_ctrl.sv
design/sbot_prep.sv
design/sbot_cross.sv
design/segment_box_overlap_test_top.sv
tb/tb_top.sv
